/* src/layer_blend_byte_macros.svh */
// ----------------------------------------------------------------------------
// layer_blend_byte assertion macros
// Clocked implication checks, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef LAYER_BLEND_BYTE_MACROS_SVH
`define LAYER_BLEND_BYTE_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define LBB_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("layer_blend_byte: same-cycle check failed");
// next-cycle implication
`define LBB_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("layer_blend_byte: next-cycle check failed");
`else
`define LBB_ASSERT_IMP(label, clk, rst, ante, cons)
`define LBB_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

/* src/lbb_pkg.sv */
// ----------------------------------------------------------------------------
// lbb_pkg
// Shared constants and types of the layer blend datapath.
// ----------------------------------------------------------------------------
package lbb_pkg;

  localparam int BYTE_W = 8;
  localparam int MODE_W = 3;
  // dividend: at most 9 bits times 8 bits
  localparam int NUM_W  = 17;

  localparam logic [BYTE_W-1:0] FULL_SCALE = 8'd255;
  localparam logic [BYTE_W-1:0] HALF_POINT = 8'd128;
  localparam logic [BYTE_W-1:0] ZERO_BYTE  = 8'd0;
  localparam logic [BYTE_W-1:0] UNIT_DEN   = 8'd1;

  typedef enum logic [MODE_W-1:0] {
    MODE_MULTIPLY = 3'd0,
    MODE_SCREEN   = 3'd1,
    MODE_OVERLAY  = 3'd2,
    MODE_DODGE    = 3'd3,
    MODE_BURN     = 3'd4
  } blend_mode_t;

  // how the quotient is turned into the result byte
  typedef struct packed {
    logic              force_en;   // result is force_val, quotient ignored
    logic [BYTE_W-1:0] force_val;
    logic              invert;     // result is 255 - quotient
    logic              sat_full;   // on overflow: 1 gives 255, 0 gives 0
  } ctrl_t;

endpackage

/* src/layer_blend_byte.sv */
// ----------------------------------------------------------------------------
// layer_blend_byte
// Blends one top-layer channel byte with the matching base-layer byte.
// ----------------------------------------------------------------------------
// Takes one beat per clock while nothing stalls: one multiplier stage forms
// the dividend, a three-stage divider works out the quotient (all modes,
// /255 included, share it) and an output register applies the mode's final
// step. Empty stages close up under a stall on the output, so new beats keep
// entering until the pipeline is full.
// blend_mode is 0 multiply, 1 screen, 2 overlay, 3 colour dodge, 4 colour burn;
// codes 5 to 7 pass top_value through. Write it only while the pipeline is
// empty.
`include "layer_blend_byte_macros.svh"

module layer_blend_byte (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [lbb_pkg::MODE_W-1:0]      cfg_wr_data,
  input  logic                            pix_valid,
  output logic                            pix_stall,
  input  logic [lbb_pkg::BYTE_W-1:0]      top_value,
  input  logic [lbb_pkg::BYTE_W-1:0]      base_value,
  output logic                            blend_valid,
  input  logic                            blend_stall,
  output logic [lbb_pkg::BYTE_W-1:0]      blended_value
);
  import lbb_pkg::*;

  logic [MODE_W-1:0] blend_mode;

  // stage 0: operand selection and product
  logic              p0_vld;
  logic [NUM_W-1:0]  p0_num;
  logic [BYTE_W-1:0] p0_den;
  ctrl_t             p0_ctrl;
  logic              p0_load;
  logic              div_stall;

  logic [BYTE_W:0]   mul_x;
  logic [BYTE_W-1:0] mul_y;
  logic [BYTE_W-1:0] den_next;
  ctrl_t             ctrl_next;
  logic [BYTE_W-1:0] inv_top, inv_base;

  logic              div_vld;
  logic [BYTE_W-1:0] div_quo;
  logic              div_sat;
  ctrl_t             div_ctrl;

  logic              o_vld;
  logic [BYTE_W-1:0] o_value;
  logic [BYTE_W-1:0] o_value_next;
  logic              o_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode <= MODE_MULTIPLY;
    end else if (cfg_wr_en) begin
      blend_mode <= cfg_wr_data;
    end
  end

  assign inv_top  = FULL_SCALE - top_value;
  assign inv_base = FULL_SCALE - base_value;

  always_comb begin
    mul_x     = {1'b0, top_value};
    mul_y     = base_value;
    den_next  = FULL_SCALE;
    ctrl_next = '{force_en: 1'b0, force_val: ZERO_BYTE, invert: 1'b0, sat_full: 1'b0};
    case (blend_mode)
      MODE_MULTIPLY: begin
        mul_x = {1'b0, top_value};
        mul_y = base_value;
      end
      MODE_SCREEN: begin
        mul_x            = {1'b0, inv_top};
        mul_y            = inv_base;
        ctrl_next.invert = 1'b1;
      end
      MODE_OVERLAY: begin
        if (base_value < HALF_POINT) begin
          mul_x = {top_value, 1'b0};
          mul_y = base_value;
        end else begin
          mul_x            = {inv_top, 1'b0};
          mul_y            = inv_base;
          ctrl_next.invert = 1'b1;
        end
      end
      MODE_DODGE: begin
        mul_x              = {1'b0, top_value};
        mul_y              = FULL_SCALE;
        den_next           = inv_base;
        ctrl_next.sat_full = 1'b1;
        if (base_value == FULL_SCALE) begin
          den_next            = UNIT_DEN;
          ctrl_next.force_en  = 1'b1;
          ctrl_next.force_val = FULL_SCALE;
        end
      end
      MODE_BURN: begin
        mul_x            = {1'b0, inv_top};
        mul_y            = FULL_SCALE;
        den_next         = base_value;
        ctrl_next.invert = 1'b1;
        if (base_value == ZERO_BYTE) begin
          den_next            = UNIT_DEN;
          ctrl_next.force_en  = 1'b1;
          ctrl_next.force_val = ZERO_BYTE;
        end
      end
      default: begin
        // unused code: top byte passes unchanged
        den_next            = UNIT_DEN;
        ctrl_next.force_en  = 1'b1;
        ctrl_next.force_val = top_value;
      end
    endcase
  end

  assign p0_load   = !p0_vld || !div_stall;
  assign pix_stall = !p0_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_vld <= 1'b0;
    end else if (p0_load) begin
      p0_vld <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p0_load) begin
      p0_num  <= NUM_W'(mul_x) * NUM_W'(mul_y);
      p0_den  <= den_next;
      p0_ctrl <= ctrl_next;
    end
  end

  lbb_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .up_valid (p0_vld),
    .up_stall (div_stall),
    .up_num   (p0_num),
    .up_den   (p0_den),
    .up_ctrl  (p0_ctrl),
    .dn_valid (div_vld),
    .dn_stall (!o_load),
    .dn_quo   (div_quo),
    .dn_sat   (div_sat),
    .dn_ctrl  (div_ctrl)
  );

  // final step: forced value, overflow clamp, or (inverted) quotient
  always_comb begin
    if (div_ctrl.force_en) begin
      o_value_next = div_ctrl.force_val;
    end else if (div_sat) begin
      o_value_next = div_ctrl.sat_full ? FULL_SCALE : ZERO_BYTE;
    end else if (div_ctrl.invert) begin
      o_value_next = FULL_SCALE - div_quo;
    end else begin
      o_value_next = div_quo;
    end
  end

  assign o_load = !o_vld || !blend_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (o_load) begin
      o_vld <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      o_value <= o_value_next;
    end
  end

  assign blend_valid   = o_vld;
  assign blended_value = o_value;

  // divider never sees a zero divisor
  `LBB_ASSERT_IMP(a_den_nonzero, clk, rst, p0_vld, p0_den != ZERO_BYTE)
  // anything divided by 255 fits in a byte
  `LBB_ASSERT_IMP(a_div255_fits, clk, rst, p0_vld && p0_den == FULL_SCALE, p0_num < {1'b0, FULL_SCALE, ZERO_BYTE})
  // input is held back only by an occupied first stage
  `LBB_ASSERT_IMP(a_stall_cause, clk, rst, pix_stall, p0_vld && div_stall)

endmodule

/* src/lbb_divider.sv */
// ----------------------------------------------------------------------------
// lbb_divider
// Three-stage restoring divider, 17-bit dividend by 8-bit divisor, quotient
// limited to 8 bits with an overflow flag. Control rides along with the beat.
// ----------------------------------------------------------------------------
`include "layer_blend_byte_macros.svh"

module lbb_divider (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            up_valid,
  output logic                            up_stall,
  input  logic [lbb_pkg::NUM_W-1:0]       up_num,
  input  logic [lbb_pkg::BYTE_W-1:0]      up_den,
  input  lbb_pkg::ctrl_t                  up_ctrl,
  output logic                            dn_valid,
  input  logic                            dn_stall,
  output logic [lbb_pkg::BYTE_W-1:0]      dn_quo,
  output logic                            dn_sat,
  output lbb_pkg::ctrl_t                  dn_ctrl
);
  import lbb_pkg::*;

  logic              d1_vld, d2_vld, d3_vld;
  logic [NUM_W-1:0]  d1_rem, d2_rem, d3_rem;
  logic [BYTE_W-1:0] d1_den, d2_den, d3_den;
  logic [BYTE_W-1:0] d1_quo, d2_quo, d3_quo;
  logic              d1_sat, d2_sat, d3_sat;
  ctrl_t             d1_ctrl, d2_ctrl, d3_ctrl;

  logic              d1_load, d2_load, d3_load;
  logic [NUM_W-1:0]  d1_rem_next, d2_rem_next, d3_rem_next;
  logic [BYTE_W-1:0] d1_quo_next, d2_quo_next, d3_quo_next;
  logic              d1_sat_next;
  logic [NUM_W-1:0]  sh1, sh2, sh3;

  // a stage takes a beat when it is empty or its beat moves on
  assign d3_load  = !d3_vld || !dn_stall;
  assign d2_load  = !d2_vld || d3_load;
  assign d1_load  = !d1_vld || d2_load;
  assign up_stall = !d1_load;

  // overflow check and quotient bits 7..6
  always_comb begin
    d1_sat_next = up_num >= {1'b0, up_den, ZERO_BYTE};
    d1_rem_next = up_num;
    d1_quo_next = '0;
    sh1         = '0;
    for (int i = 7; i >= 6; i--) begin
      sh1 = NUM_W'(up_den) << i;
      if (d1_rem_next >= sh1) begin
        d1_rem_next     = d1_rem_next - sh1;
        d1_quo_next[3'(i)] = 1'b1;
      end
    end
  end

  // quotient bits 5..3
  always_comb begin
    d2_rem_next = d1_rem;
    d2_quo_next = d1_quo;
    sh2         = '0;
    for (int i = 5; i >= 3; i--) begin
      sh2 = NUM_W'(d1_den) << i;
      if (d2_rem_next >= sh2) begin
        d2_rem_next     = d2_rem_next - sh2;
        d2_quo_next[3'(i)] = 1'b1;
      end
    end
  end

  // quotient bits 2..0
  always_comb begin
    d3_rem_next = d2_rem;
    d3_quo_next = d2_quo;
    sh3         = '0;
    for (int i = 2; i >= 0; i--) begin
      sh3 = NUM_W'(d2_den) << i;
      if (d3_rem_next >= sh3) begin
        d3_rem_next     = d3_rem_next - sh3;
        d3_quo_next[3'(i)] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_vld <= 1'b0;
      d2_vld <= 1'b0;
      d3_vld <= 1'b0;
    end else begin
      if (d1_load) d1_vld <= up_valid;
      if (d2_load) d2_vld <= d1_vld;
      if (d3_load) d3_vld <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (d1_load) begin
      d1_rem  <= d1_rem_next;
      d1_den  <= up_den;
      d1_quo  <= d1_quo_next;
      d1_sat  <= d1_sat_next;
      d1_ctrl <= up_ctrl;
    end
    if (d2_load) begin
      d2_rem  <= d2_rem_next;
      d2_den  <= d1_den;
      d2_quo  <= d2_quo_next;
      d2_sat  <= d1_sat;
      d2_ctrl <= d1_ctrl;
    end
    if (d3_load) begin
      d3_rem  <= d3_rem_next;
      d3_den  <= d2_den;
      d3_quo  <= d3_quo_next;
      d3_sat  <= d2_sat;
      d3_ctrl <= d2_ctrl;
    end
  end

  assign dn_valid = d3_vld;
  assign dn_quo   = d3_quo;
  assign dn_sat   = d3_sat;
  assign dn_ctrl  = d3_ctrl;

  // partial remainders stay below the next divisor multiple
  `LBB_ASSERT_IMP(a_d1_rem_bound, clk, rst, d1_vld && !d1_sat, d1_rem < (NUM_W'(d1_den) << 6))
  `LBB_ASSERT_IMP(a_d2_rem_bound, clk, rst, d2_vld && !d2_sat, d2_rem < (NUM_W'(d2_den) << 3))
  `LBB_ASSERT_IMP(a_d3_rem_bound, clk, rst, d3_vld && !d3_sat, d3_rem < NUM_W'(d3_den))

endmodule
